### design/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue.
// Each macro takes a label, the clock, the active-low reset and the check.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DEQ_ASSERT(label, clk, rst_n, prop, msg)
`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 6;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int FUNC_W = 3;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 7;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PEEK_BACK  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_GET        = 3'd5;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd6;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [WORD_W-1:0] data_in;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] data_out;
		logic [LEN_W-1:0]  length;
	} rsp_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic                  shift;
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_idx;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  bus_en;
		logic [IDX_W-1:0]      rd_idx;
	} cell_ctl_t;

endpackage

`default_nettype wire

### design/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One element of the queue row plus one hop of the read chain.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
	input  wire logic                           clk,
	input  wire deq_pkg::cell_ctl_t             ctl,
	input  wire logic [deq_pkg::IDX_W-1:0]      idx,
	input  wire logic [deq_pkg::DATA_WIDTH-1:0] left_data,
	input  wire logic [deq_pkg::DATA_WIDTH-1:0] right_bus,
	output logic      [deq_pkg::DATA_WIDTH-1:0] data,
	output logic      [deq_pkg::DATA_WIDTH-1:0] bus
);

	logic [deq_pkg::DATA_WIDTH-1:0] data_q;
	logic [deq_pkg::DATA_WIDTH-1:0] bus_q;

	// push front moves every element one place towards the back
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= left_data;
		end else if (ctl.wr_en && (idx == ctl.wr_idx)) begin
			data_q <= ctl.wdata;
		end
	end

	// read chain: the selected cell injects its word, the rest pass theirs forward
	always_ff @(posedge clk) begin
		if (ctl.bus_en) begin
			bus_q <= (idx == ctl.rd_idx) ? data_q : right_bus;
		end
	end

	assign data = data_q;
	assign bus  = bus_q;

endmodule

`default_nettype wire

### design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Request decode, element count and result register for the queue row.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_macros.svh"

module deq_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire deq_pkg::req_t                  req,
	output logic                                strobe,
	output deq_pkg::rsp_t                       rsp,
	output deq_pkg::cell_ctl_t                  ctl,
	input  wire logic [deq_pkg::DATA_WIDTH-1:0] bus0
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic                        busy_q;
	logic                        strobe_q;
	logic                        ok_q;
	logic [deq_pkg::WORD_W-1:0]  data_q;
	logic [deq_pkg::CNT_W-1:0]   count_q;
	logic [deq_pkg::IDX_W-1:0]   rd_idx_q;
	logic [deq_pkg::IDX_W-1:0]   hop_q;
	logic                        pop_q;

	logic                        accept;
	logic                        not_full;
	logic                        not_empty;
	logic                        pos_ok;
	logic                        imm_ok;
	logic                        rd_ok;
	logic [deq_pkg::IDX_W-1:0]   rd_tgt;
	logic [deq_pkg::CNT_W-1:0]   count_nxt;
	logic [deq_pkg::CNT_W-1:0]   last_pos;

	assign accept    = start && !busy_q;
	assign not_full  = count_q < deq_pkg::CNT_W'(deq_pkg::DEPTH);
	assign not_empty = count_q != '0;
	assign pos_ok    = deq_pkg::CMP_W'(req.position) < deq_pkg::CMP_W'(count_q);
	assign last_pos  = count_q - 1'b1;

	always_comb begin
		imm_ok    = 1'b0;
		rd_ok     = 1'b0;
		rd_tgt    = '0;
		count_nxt = count_q;
		unique case (req.func) inside
			deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
				imm_ok = not_full;
				if (not_full) begin
					count_nxt = count_q + 1'b1;
				end
			end
			deq_pkg::FN_POP_BACK, deq_pkg::FN_PEEK_BACK: begin
				rd_ok  = not_empty;
				rd_tgt = deq_pkg::IDX_W'(last_pos);
			end
			deq_pkg::FN_PEEK_FRONT: begin
				rd_ok = not_empty;
			end
			deq_pkg::FN_GET: begin
				rd_ok  = pos_ok;
				rd_tgt = deq_pkg::IDX_W'(req.position);
			end
			deq_pkg::FN_CLEAR: begin
				imm_ok    = 1'b1;
				count_nxt = '0;
			end
			default: begin
				imm_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctl.shift  = accept && (req.func == deq_pkg::FN_PUSH_FRONT) && not_full;
		ctl.wr_en  = accept && (req.func == deq_pkg::FN_PUSH_BACK) && not_full;
		ctl.wr_idx = deq_pkg::IDX_W'(count_q);
		ctl.wdata  = deq_pkg::DATA_WIDTH'(req.data_in);
		ctl.bus_en = state_q == ST_READ;
		ctl.rd_idx = rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
			ok_q     <= 1'b0;
			data_q   <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			hop_q    <= '0;
			pop_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (rd_ok) begin
							state_q  <= ST_READ;
							busy_q   <= 1'b1;
							rd_idx_q <= rd_tgt;
							hop_q    <= rd_tgt;
							pop_q    <= req.func == deq_pkg::FN_POP_BACK;
						end else begin
							strobe_q <= 1'b1;
							ok_q     <= imm_ok;
							data_q   <= '0;
							count_q  <= count_nxt;
						end
					end
				end
				// word travels one cell per cycle towards cell 0
				ST_READ: begin
					if (hop_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						hop_q <= hop_q - 1'b1;
					end
				end
				ST_FINISH: begin
					state_q  <= ST_IDLE;
					busy_q   <= 1'b0;
					strobe_q <= 1'b1;
					ok_q     <= 1'b1;
					data_q   <= deq_pkg::WORD_W'(bus0);
					if (pop_q) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy         = busy_q;
	assign strobe       = strobe_q;
	assign rsp.ok       = ok_q;
	assign rsp.data_out = data_q;
	assign rsp.length   = deq_pkg::LEN_W'(count_q);

	`DEQ_ASSERT_IMPL(a_fail_zero, clk, arst_n, strobe_q && !ok_q, data_q == '0, "failed result carries data")
	`DEQ_ASSERT_NEXT(a_hop_end, clk, arst_n, (state_q == ST_READ) && (hop_q == '0), (state_q == ST_FINISH) && busy_q, "read chain did not finish")
	`DEQ_ASSERT_NEXT(a_finish_out, clk, arst_n, state_q == ST_FINISH, strobe_q && ok_q && !busy_q, "read result not delivered")
	`DEQ_ASSERT_IMPL(a_busy_quiet, clk, arst_n, $rose(busy_q), !strobe_q, "result strobed on read start")
	`DEQ_ASSERT(a_count_max, clk, arst_n, count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "count beyond depth")

endmodule

`default_nettype wire

### design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue built as a row of element cells.
// ----------------------------------------------------------------------------
// A request (func, data_in, position in req) transfers at a rising edge with
// start high and busy low. Every request gives exactly one result on rsp,
// shown for one cycle with strobe high; the receiver cannot stall it.
// Cell i holds the element i places from the front. Push front shifts the
// whole row by one, push back writes the cell at the current length, clear
// only zeroes the count; each of these, and any failed request, answers in
// the cycle after the transfer and leaves busy low, so one is taken per cycle.
// Pop back, peek and get run a read chain: the selected cell puts its word on
// the chain and it moves one cell per cycle towards cell 0. Busy stays high
// while the word travels from cell p to the result register, p being the
// position read (0 for peek front, length-1 for the back). The result strobes
// in the cycle in which busy falls, and the next request can transfer in that same cycle.
// Reset clears the count, control and strobe; cell contents are not reset
// and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire deq_pkg::req_t req,
	output logic               strobe,
	output deq_pkg::rsp_t      rsp
);

	deq_pkg::cell_ctl_t             ctl;
	logic [deq_pkg::DATA_WIDTH-1:0] left_chain [deq_pkg::DEPTH+1];
	logic [deq_pkg::DATA_WIDTH-1:0] bus_chain  [deq_pkg::DEPTH+1];

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp),
		.ctl    (ctl),
		.bus0   (bus_chain[0])
	);

	// the front cell takes the pushed word, the far end of the chain reads zero
	assign left_chain[0]             = ctl.wdata;
	assign bus_chain[deq_pkg::DEPTH] = '0;

	for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
		deq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (deq_pkg::IDX_W'(i)),
			.left_data (left_chain[i]),
			.right_bus (bus_chain[i+1]),
			.data      (left_chain[i+1]),
			.bus       (bus_chain[i])
		);
	end

endmodule

`default_nettype wire
